// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the pump fault supervisor.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/pfs_pkg.sv =====
// Package for the pump fault supervisor: action codes, register indexes,
// reset values and the drive error code tables. No dependencies.
package pfs_pkg;

  // Action reported with every result item.
  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_FAIL_HARD    = 3'd1,
    ACT_RESET_PUMP   = 3'd2,
    ACT_FAIL_NORESET = 3'd3,
    ACT_FAIL_UNKNOWN = 3'd4
  } pfs_action_e;

  // Configuration register indexes.
  localparam logic CFG_STATUS_MASK = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  // Reset values.
  localparam logic [15:0] STATUS_MASK_RST = 16'h0EBF;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;
  localparam logic [15:0] PREV_RST        = 16'hFFFF;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;

  // Number of published status flags.
  localparam int unsigned NUM_FLAGS = 10;

  // Codes that the drive can never clear by itself.
  function automatic logic is_hard_code(input logic [15:0] code);
    logic hit;
    hit = 1'b0;
    case (code)
      16'd3, 16'd12, 16'd15, 16'd33, 16'd38, 16'd39, 16'd40, 16'd41, 16'd42,
      16'd43, 16'd64, 16'd70, 16'd71, 16'd72, 16'd73, 16'd80, 16'd81, 16'd82,
      16'd83, 16'd91, 16'd94, 16'd100, 16'd101, 16'd105, 16'd106, 16'd107,
      16'd109, 16'd110, 16'd111, 16'd114, 16'd122, 16'd125, 16'd126,
      16'd127: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Codes that a pump reset is expected to clear.
  function automatic logic is_auto_code(input logic [15:0] code);
    logic hit;
    hit = 1'b0;
    case (code)
      16'd2, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd13, 16'd21,
      16'd29, 16'd48, 16'd59, 16'd63: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== src/pump_fault_supervisor_unit.sv =====
// Top level of the pump fault supervisor: input register, classification
// and status decode, result register. Depends on pfs_pkg.
//
//  channel | direction | handshake              | payload
//  in      | to block  | in_valid_i, in_stall_o | status_word_i, error_code_i
//  out     | from block| out_valid_o, out_stall_i| action_o, publish_o, flag bits
//  cfg     | to block  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle is accepted while in_stall_o is low; its result is offered once
// the item has passed the input register and then the result register.
// The supervisor state updates as an item moves from the input register to
// the result register, so back-to-back items see each other's effect.
// A stall on the output holds the result register and, when the input
// register is also full, raises in_stall_o in the same cycle.
// Reset clears the valid bits and the repeat counter, sets the stored status
// and code to all ones, and loads the register reset values.
module pump_fault_supervisor_unit
  import pfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] status_word_i,
  input  logic [15:0] error_code_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic        publish_o,
  output logic        ready_res_o,
  output logic        running_o,
  output logic        forward_commanded_o,
  output logic        forward_rotating_o,
  output logic        accelerating_o,
  output logic        decelerating_o,
  output logic        faulted_o,
  output logic        frequency_from_main_o,
  output logic        command_from_operation_o,
  output logic        parameters_locked_o
);

  // Configuration registers.
  logic [15:0] status_mask_q;
  logic [7:0]  retry_limit_q;

  // Input register.
  logic        in_vld_q;
  logic [15:0] in_status_q;
  logic [15:0] in_code_q;

  // Supervisor state.
  logic [15:0] prev_status_q, prev_status_d;
  logic [15:0] prev_error_q, prev_error_d;
  logic [7:0]  repeat_cnt_q, repeat_cnt_d;

  // Result register.
  logic                 out_vld_q;
  pfs_action_e          action_q, action_d;
  logic                 publish_q, publish_d;
  logic [NUM_FLAGS-1:0] flags_q, flags_d;

  // Handshake control.
  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_move    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_mask_q <= STATUS_MASK_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STATUS_MASK: status_mask_q <= cfg_data_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (s1_move) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_status_q <= status_word_i;
      in_code_q   <= error_code_i;
    end
  end

  // Classification, repeat counting and status decode for the held item.
  logic [15:0] masked;
  logic [7:0]  cnt_inc;
  logic        pub;

  always_comb begin
    masked       = in_status_q & status_mask_q;
    action_d     = ACT_NONE;
    repeat_cnt_d = repeat_cnt_q;
    cnt_inc      = (repeat_cnt_q == COUNT_MAX) ? repeat_cnt_q : repeat_cnt_q + 8'd1;

    if (in_code_q != 16'd0) begin
      if (is_hard_code(in_code_q)) begin
        action_d = ACT_FAIL_HARD;
      end else if (is_auto_code(in_code_q)) begin
        if (in_code_q != prev_error_q) begin
          action_d = ACT_RESET_PUMP;
        end else begin
          repeat_cnt_d = cnt_inc;
          if (cnt_inc > retry_limit_q) begin
            action_d = ACT_FAIL_NORESET;
          end
        end
      end else begin
        action_d = ACT_FAIL_UNKNOWN;
      end
    end else begin
      repeat_cnt_d = 8'd0;
    end

    pub       = (masked != prev_status_q) || (in_code_q != prev_error_q);
    publish_d = pub;

    // Flags are shown only on a publishing item.
    flags_d = pub ? {masked[11], masked[10], masked[9], masked[7], masked[5],
                     masked[4], masked[3], masked[2], masked[1], masked[0]}
                  : '0;

    prev_status_d = pub ? masked : prev_status_q;
    prev_error_d  = pub ? in_code_q : prev_error_q;
  end

  // Supervisor state update as the item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_status_q <= PREV_RST;
      prev_error_q  <= PREV_RST;
      repeat_cnt_q  <= 8'd0;
    end else if (s1_move) begin
      prev_status_q <= prev_status_d;
      prev_error_q  <= prev_error_d;
      repeat_cnt_q  <= repeat_cnt_d;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_move;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      action_q  <= action_d;
      publish_q <= publish_d;
      flags_q   <= flags_d;
    end
  end

  // Output ports.
  assign out_valid_o              = out_vld_q;
  assign action_o                 = action_q;
  assign publish_o                = publish_q;
  assign ready_res_o              = flags_q[0];
  assign running_o                = flags_q[1];
  assign forward_commanded_o      = flags_q[2];
  assign forward_rotating_o       = flags_q[3];
  assign accelerating_o           = flags_q[4];
  assign decelerating_o           = flags_q[5];
  assign faulted_o                = flags_q[6];
  assign frequency_from_main_o    = flags_q[7];
  assign command_from_operation_o = flags_q[8];
  assign parameters_locked_o      = flags_q[9];

endmodule

// ===== src/pfs_checker.sv =====
// Port-level checks for the pump fault supervisor, bound to its top level.
// Depends on pfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfs_checker
  import pfs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic       publish_o,
  input logic       ready_res_o,
  input logic       running_o,
  input logic       forward_commanded_o,
  input logic       forward_rotating_o,
  input logic       accelerating_o,
  input logic       decelerating_o,
  input logic       faulted_o,
  input logic       frequency_from_main_o,
  input logic       command_from_operation_o,
  input logic       parameters_locked_o
);

  logic any_flag;

  assign any_flag = ready_res_o | running_o | forward_commanded_o | forward_rotating_o |
                    accelerating_o | decelerating_o | faulted_o | frequency_from_main_o |
                    command_from_operation_o | parameters_locked_o;

  // A stalled result item stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Only defined action codes are reported.
  `ASSERT_IMPLIES(a_action_legal, clk_i, rst_ni, out_valid_o,
    action_o == ACT_NONE || action_o == ACT_FAIL_HARD || action_o == ACT_RESET_PUMP ||
    action_o == ACT_FAIL_NORESET || action_o == ACT_FAIL_UNKNOWN)

  // Without publication no status flag is shown.
  `ASSERT_IMPLIES(a_flags_quiet, clk_i, rst_ni, out_valid_o && !publish_o, !any_flag)

  // A reset request comes from a new code, which always publishes.
  `ASSERT_IMPLIES(a_reset_publishes, clk_i, rst_ni,
    out_valid_o && action_o == ACT_RESET_PUMP, publish_o)

endmodule

bind pump_fault_supervisor_unit pfs_checker u_pfs_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .out_valid_o              (out_valid_o),
  .out_stall_i              (out_stall_i),
  .action_o                 (action_o),
  .publish_o                (publish_o),
  .ready_res_o              (ready_res_o),
  .running_o                (running_o),
  .forward_commanded_o      (forward_commanded_o),
  .forward_rotating_o       (forward_rotating_o),
  .accelerating_o           (accelerating_o),
  .decelerating_o           (decelerating_o),
  .faulted_o                (faulted_o),
  .frequency_from_main_o    (frequency_from_main_o),
  .command_from_operation_o (command_from_operation_o),
  .parameters_locked_o      (parameters_locked_o)
);

// ===== verif/tb_pump_fault_supervisor_unit.sv =====
`timescale 1ns / 1ps
// Testbench for pump_fault_supervisor_unit: a directed table, then phases of random polls,
// checked against table values or a local predictor. Depends on pfs_pkg and the RTL.
module tb_pump_fault_supervisor_unit;
  import pfs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PLAN_ROWS   = 25;

  // Decoded result of one poll, flags in port order from ready_res upward.
  typedef struct packed {
    pfs_action_e action;
    logic        publish;
    logic [9:0]  flags;
  } poll_result_t;

  // One row of the directed table; want is used only when given is set.
  typedef struct packed {
    logic [15:0]  status;
    logic [15:0]  code;
    logic         given;
    poll_result_t want;
  } plan_row_t;

  typedef enum logic [1:0] {
    CODE_CLEAR,
    CODE_HARD,
    CODE_AUTO,
    CODE_UNKNOWN
  } code_class_e;

  localparam poll_result_t NO_WANT = '{ACT_NONE, 1'b0, 10'h000};

  // Drive error code classes.
  localparam logic [12:0][15:0] AUTO_CODES = {
    16'd2, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd13, 16'd21, 16'd29, 16'd48,
    16'd59, 16'd63};
  localparam logic [33:0][15:0] HARD_CODES = {
    16'd3, 16'd12, 16'd15, 16'd33, 16'd38, 16'd39, 16'd40, 16'd41, 16'd42, 16'd43,
    16'd64, 16'd70, 16'd71, 16'd72, 16'd73, 16'd80, 16'd81, 16'd82, 16'd83, 16'd91,
    16'd94, 16'd100, 16'd101, 16'd105, 16'd106, 16'd107, 16'd109, 16'd110, 16'd111,
    16'd114, 16'd122, 16'd125, 16'd126, 16'd127};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] status_word_i;
  logic [15:0] error_code_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic        publish_o;
  logic        ready_res_o;
  logic        running_o;
  logic        forward_commanded_o;
  logic        forward_rotating_o;
  logic        accelerating_o;
  logic        decelerating_o;
  logic        faulted_o;
  logic        frequency_from_main_o;
  logic        command_from_operation_o;
  logic        parameters_locked_o;

  // Supervisor state as the predictor sees it.
  logic [15:0] model_mask  = STATUS_MASK_RST;
  logic [7:0]  model_limit = RETRY_LIMIT_RST;
  logic [15:0] seen_status = PREV_RST;
  logic [15:0] seen_code   = PREV_RST;
  logic [7:0]  repeat_cnt  = 8'd0;

  poll_result_t pending_results [$];
  logic [15:0]  poll_status = 16'h0000;
  bit           no_idle     = 1'b0;
  int           polls_sent   = 0;
  int           results_seen = 0;
  int           mismatches   = 0;
  int           cycle_count  = 0;
  int           action_hits [5] = '{0, 0, 0, 0, 0};

  string flag_names [10] = '{"ready_res", "running", "forward_commanded", "forward_rotating",
                             "accelerating", "decelerating", "faulted",
                             "frequency_from_main", "command_from_operation",
                             "parameters_locked"};

  // Directed table: reset-value match, extremes, every code class, retry runs.
  plan_row_t plan [PLAN_ROWS] = '{
    '{16'hFFFF, 16'hFFFF, 1'b1, '{ACT_FAIL_UNKNOWN, 1'b0, 10'h000}},
    '{16'h0000, 16'h0000, 1'b1, '{ACT_NONE, 1'b1, 10'h000}},
    '{16'hFFFF, 16'h0000, 1'b1, '{ACT_NONE, 1'b1, 10'h3FF}},
    '{16'hFFFF, 16'h0000, 1'b1, '{ACT_NONE, 1'b0, 10'h000}},
    '{16'h0001, 16'h0003, 1'b1, '{ACT_FAIL_HARD, 1'b1, 10'h001}},
    '{16'h0001, 16'h007F, 1'b1, '{ACT_FAIL_HARD, 1'b1, 10'h001}},
    '{16'h0002, 16'h0005, 1'b1, '{ACT_RESET_PUMP, 1'b1, 10'h002}},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h0005, 1'b0, NO_WANT},
    '{16'h0002, 16'h003F, 1'b0, NO_WANT},
    '{16'h0002, 16'h003F, 1'b0, NO_WANT},
    '{16'h0002, 16'h000C, 1'b0, NO_WANT},
    '{16'h0002, 16'h0000, 1'b0, NO_WANT},
    '{16'h0002, 16'h003F, 1'b0, NO_WANT},
    '{16'h0002, 16'h003F, 1'b0, NO_WANT},
    '{16'h0AAA, 16'h0001, 1'b0, NO_WANT},
    '{16'h0555, 16'h0080, 1'b0, NO_WANT},
    '{16'hF140, 16'h8000, 1'b0, NO_WANT},
    '{16'h0000, 16'hFFFF, 1'b0, NO_WANT},
    '{16'h0000, 16'h0000, 1'b0, NO_WANT}
  };

  pump_fault_supervisor_unit DUT (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .status_word_i            (status_word_i),
    .error_code_i             (error_code_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .action_o                 (action_o),
    .publish_o                (publish_o),
    .ready_res_o              (ready_res_o),
    .running_o                (running_o),
    .forward_commanded_o      (forward_commanded_o),
    .forward_rotating_o       (forward_rotating_o),
    .accelerating_o           (accelerating_o),
    .decelerating_o           (decelerating_o),
    .faulted_o                (faulted_o),
    .frequency_from_main_o    (frequency_from_main_o),
    .command_from_operation_o (command_from_operation_o),
    .parameters_locked_o      (parameters_locked_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sorts a drive error code into its class.
  function automatic code_class_e classify_code(input logic [15:0] ec);
    code_class_e cls;
    int          k;
    cls = (ec == 16'd0) ? CODE_CLEAR : CODE_UNKNOWN;
    for (k = 0; k < 34; k++) begin
      if (HARD_CODES[k] == ec) cls = CODE_HARD;
    end
    for (k = 0; k < 13; k++) begin
      if (AUTO_CODES[k] == ec) cls = CODE_AUTO;
    end
    return cls;
  endfunction

  // Works out the result of one poll and advances the supervisor state.
  function automatic poll_result_t supervise_poll(input logic [15:0] raw,
                                                  input logic [15:0] ec);
    poll_result_t res;
    logic [15:0]  st;
    st  = raw & model_mask;
    res = NO_WANT;
    case (classify_code(ec))
      CODE_CLEAR: repeat_cnt = 8'd0;
      CODE_HARD: res.action = ACT_FAIL_HARD;
      CODE_AUTO: begin
        if (ec != seen_code) begin
          res.action = ACT_RESET_PUMP;
        end else begin
          // The repeat counter saturates instead of wrapping.
          if (repeat_cnt != COUNT_MAX) repeat_cnt = repeat_cnt + 8'd1;
          if (repeat_cnt > model_limit) res.action = ACT_FAIL_NORESET;
        end
      end
      default: res.action = ACT_FAIL_UNKNOWN;
    endcase
    res.publish = (st != seen_status) || (ec != seen_code);
    // Flags stay zero unless something changed.
    if (res.publish) begin
      res.flags   = {st[11], st[10], st[9], st[7], st[5:0]};
      seen_status = st;
      seen_code   = ec;
    end
    return res;
  endfunction

  // Writes one configuration register and mirrors it in the predictor.
  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STATUS_MASK) begin
      model_mask = data;
    end else begin
      model_limit = data[7:0];
    end
  endtask

  // Offers one poll after a random gap and records its expected result once accepted.
  task automatic send_poll(input logic [15:0] st, input logic [15:0] ec, input logic given,
                           input poll_result_t want);
    int           gap;
    poll_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    status_word_i <= st;
    error_code_i  <= ec;
    do @(posedge clk_i); while (in_stall_o);
    pred = supervise_poll(st, ec);
    pending_results.push_back(given ? want : pred);
    polls_sent++;
  endtask

  // Stops offering and waits until every pending result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drains the block, then loads a new register setting.
  task automatic set_phase(input logic [15:0] mask, input logic [7:0] limit);
    drain_results();
    write_reg(CFG_STATUS_MASK, mask);
    write_reg(CFG_RETRY_LIMIT, {8'h00, limit});
  endtask

  // Random polls: mostly retry runs of one auto-reset code, the rest other classes and noise.
  task automatic run_random(input int count);
    int          sent;
    int          kind;
    int          len;
    int          j;
    logic [15:0] ec;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) poll_status = 16'($urandom_range(0, 65535));
      if (kind < 50) begin
        ec  = AUTO_CODES[$urandom_range(0, 12)];
        len = $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
          if ($urandom_range(0, 7) == 0) poll_status = 16'($urandom_range(0, 65535));
          send_poll(poll_status, ec, 1'b0, NO_WANT);
        end
        sent += len;
        // Often the drive recovers and reports no fault.
        if ($urandom_range(0, 1) == 0) begin
          send_poll(poll_status, 16'd0, 1'b0, NO_WANT);
          sent++;
        end
      end else begin
        if (kind < 65) begin
          ec = HARD_CODES[$urandom_range(0, 33)];
        end else if (kind < 75) begin
          ec = 16'd0;
        end else if (kind < 85) begin
          ec = 16'($urandom_range(1, 127));
        end else begin
          ec = 16'($urandom_range(0, 65535));
        end
        send_poll(poll_status, ec, 1'b0, NO_WANT);
        sent++;
      end
    end
  endtask

  // Counts a failure; only the first ten are shown.
  task automatic flag_error(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    end
  endtask

  // Stimulus: directed table, then random phases over several register settings.
  initial begin : stimulus
    int i;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_STATUS_MASK;
    cfg_data_i    = 16'h0000;
    in_valid_i    = 1'b0;
    status_word_i = 16'h0000;
    error_code_i  = 16'h0000;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A full mask lets the reset values of the stored status and code match.
    write_reg(CFG_STATUS_MASK, 16'hFFFF);
    write_reg(CFG_RETRY_LIMIT, 16'd5);
    for (i = 0; i < PLAN_ROWS; i++) begin
      send_poll(plan[i].status, plan[i].code, plan[i].given, plan[i].want);
    end

    set_phase(STATUS_MASK_RST, RETRY_LIMIT_RST);
    run_random(250);
    set_phase(16'h0000, 8'd0);
    run_random(200);
    set_phase(16'hFFFF, 8'd255);
    run_random(200);

    // Back-to-back stretch with no idling on either side.
    set_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 3)));
    no_idle = 1'b1;
    run_random(200);
    drain_results();
    no_idle = 1'b0;

    // A long run of one code drives the repeat counter into saturation.
    set_phase(STATUS_MASK_RST, 8'd10);
    send_poll(poll_status, 16'd0, 1'b0, NO_WANT);
    repeat (300) send_poll(poll_status, 16'd7, 1'b0, NO_WANT);
    run_random(100);

    set_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    run_random(200);
    drain_results();

    $display("%0d polls sent, %0d results checked over seven register settings",
             polls_sent, results_seen);
    $display("actions seen: none %0d, hard %0d, reset %0d, cannot reset %0d, unknown %0d",
             action_hits[0], action_hits[1], action_hits[2], action_hits[3],
             action_hits[4]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_pump_fault_supervisor_unit: clean");
    end else begin
      $display("tb_pump_fault_supervisor_unit: errors");
    end
    $finish;
  end

  // Result side: random stalls, two long hold-offs, and the field-by-field check.
  initial begin : result_sink
    int           hold;
    int           k;
    logic [2:0]   got_act;
    logic [9:0]   got_flags;
    poll_result_t want;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 14);
      // Hold off long enough for the block to fill up and stall its input.
      if (results_seen == 200 || results_seen == 1000) hold = 60;
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);

      got_act   = action_o;
      got_flags = {parameters_locked_o, command_from_operation_o, frequency_from_main_o,
                   faulted_o, decelerating_o, accelerating_o, forward_rotating_o,
                   forward_commanded_o, running_o, ready_res_o};
      if (got_act <= 3'd4) action_hits[got_act]++;
      if (pending_results.size() == 0) begin
        flag_error("pending results", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (got_act !== want.action) flag_error("action", want.action, got_act);
        if (publish_o !== want.publish) flag_error("publish", want.publish, publish_o);
        for (k = 0; k < NUM_FLAGS; k++) begin
          if (got_flags[k] !== want.flags[k]) begin
            flag_error(flag_names[k], want.flags[k], got_flags[k]);
          end
        end
      end
      results_seen++;
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_pump_fault_supervisor_unit: errors");
    $finish;
  end

endmodule
